### rtl/core/chol3_pkg.sv
// Shared types and constants for the 3x3 Cholesky stress check.
`timescale 1ns / 1ps
package chol3_pkg;

	localparam int DW   = 32;
	localparam int RT_W = 31;

	localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_XX_NONPOS = 3'd1,
		ST_P2_NEG    = 3'd2,
		ST_P3_NEG    = 3'd3,
		ST_P2_ZERO   = 3'd4
	} status_t;

	typedef struct packed {
		status_t                st;
		logic signed [DW-1:0]   r_xy;
		logic signed [DW-1:0]   r_xz;
		logic signed [DW-1:0]   r_yy;
		logic signed [DW-1:0]   r_yz;
		logic signed [DW-1:0]   r_zz;
	} sq1_side_t;

	typedef struct packed {
		status_t                st;
		logic [RT_W-1:0]        l_xx;
		logic signed [DW-1:0]   r_yy;
		logic signed [DW-1:0]   r_yz;
	} dv1_side_t;

	typedef struct packed {
		status_t                st;
		logic [RT_W-1:0]        l_xx;
		logic signed [DW-1:0]   l_xy;
		logic signed [DW-1:0]   l_xz;
		logic signed [2*DW-1:0] nyz;
		logic signed [2*DW-1:0] q3a;
	} sq2_side_t;

	typedef struct packed {
		status_t                st;
		logic [RT_W-1:0]        l_xx;
		logic signed [DW-1:0]   l_xy;
		logic signed [DW-1:0]   l_xz;
		logic [RT_W-1:0]        l_yy;
		logic signed [2*DW-1:0] q3a;
	} dv2_side_t;

	typedef struct packed {
		status_t                st;
		logic [RT_W-1:0]        l_xx;
		logic signed [DW-1:0]   l_xy;
		logic signed [DW-1:0]   l_xz;
		logic [RT_W-1:0]        l_yy;
		logic signed [DW-1:0]   l_yz;
	} sq3_side_t;

endpackage

### rtl/core/chol3_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
`timescale 1ns / 1ps
module chol3_sqrt #(
	parameter  int IN_W   = 55,
	parameter  int SIDE_W = 1,
	localparam int OUT_W  = (IN_W + 1) / 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   radicand,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [OUT_W-1:0]  root,
	output logic [SIDE_W-1:0] out_side
);

	localparam int R_W = IN_W + 2;

	logic [R_W-1:0]    rem_w  [0:OUT_W];
	logic [OUT_W-1:0]  res_w  [0:OUT_W];
	logic              vld_w  [0:OUT_W];
	logic [SIDE_W-1:0] side_w [0:OUT_W];

	assign rem_w[0]  = R_W'(radicand);
	assign res_w[0]  = '0;
	assign vld_w[0]  = in_valid;
	assign side_w[0] = in_side;

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		localparam int BIT = OUT_W - 1 - k;
		logic [R_W-1:0]    trial;
		logic              take;
		logic [R_W-1:0]    rem_s;
		logic [OUT_W-1:0]  res_s;
		logic              vld_s;
		logic [SIDE_W-1:0] side_s;

		// (res + 2^i)^2 - res^2 = res*2^(i+1) + 2^(2i); bits never overlap
		assign trial = (R_W'(res_w[k]) << (BIT + 1)) | (R_W'(1) << (2 * BIT));
		assign take  = rem_w[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else begin
				vld_s <= vld_w[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s  <= take ? rem_w[k] - trial : rem_w[k];
			res_s  <= res_w[k] | (take ? (OUT_W'(1) << BIT) : '0);
			side_s <= side_w[k];
		end

		assign rem_w[k+1]  = rem_s;
		assign res_w[k+1]  = res_s;
		assign vld_w[k+1]  = vld_s;
		assign side_w[k+1] = side_s;
	end

	assign out_valid = vld_w[OUT_W];
	assign root      = res_w[OUT_W];
	assign out_side  = side_w[OUT_W];

endmodule

### rtl/core/chol3_div.sv
// Pipelined signed divide by unsigned divisor, truncating, saturated to 32 bits.
`timescale 1ns / 1ps
module chol3_div import chol3_pkg::*; #(
	parameter int NUM_W  = 56,
	parameter int DEN_W  = 31,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_valid,
	output logic signed [DW-1:0] quot,
	output logic [SIDE_W-1:0]    out_side
);

	localparam int ACC_W = (NUM_W > DEN_W + DW + 1) ? NUM_W : DEN_W + DW + 1;

	logic [NUM_W-1:0]  num_mag;
	logic              vld_s0;
	logic [ACC_W-1:0]  rem_s0;
	logic [DEN_W-1:0]  den_s0;
	logic              neg_s0;
	logic [SIDE_W-1:0] side_s0;

	assign num_mag = num[NUM_W-1] ? NUM_W'(~num + 1'b1) : num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s0  <= ACC_W'(num_mag);
		den_s0  <= den;
		neg_s0  <= num[NUM_W-1];
		side_s0 <= in_side;
	end

	logic [ACC_W-1:0]  rem_w  [0:DW];
	logic [DW-1:0]     q_w    [0:DW];
	logic [DEN_W-1:0]  den_w  [0:DW];
	logic              neg_w  [0:DW];
	logic              ovf_w  [0:DW];
	logic              vld_w  [0:DW];
	logic [SIDE_W-1:0] side_w [0:DW];

	assign rem_w[0]  = rem_s0;
	assign q_w[0]    = '0;
	assign den_w[0]  = den_s0;
	assign neg_w[0]  = neg_s0;
	assign ovf_w[0]  = 1'b0;
	assign vld_w[0]  = vld_s0;
	assign side_w[0] = side_s0;

	for (genvar k = 0; k < DW; k++) begin : g_stage
		localparam int BIT = DW - 1 - k;
		logic [ACC_W-1:0]  sub;
		logic              take;
		logic              ovf_n;
		logic [ACC_W-1:0]  rem_s;
		logic [DW-1:0]     q_s;
		logic [DEN_W-1:0]  den_s;
		logic              neg_s;
		logic              ovf_s;
		logic              vld_s;
		logic [SIDE_W-1:0] side_s;

		assign sub  = ACC_W'(den_w[k]) << BIT;
		assign take = rem_w[k] >= sub;

		// quotient magnitude needs more than DW bits
		if (k == 0) begin : g_ovf
			assign ovf_n = rem_w[k] >= (ACC_W'(den_w[k]) << DW);
		end else begin : g_ovf_pass
			assign ovf_n = ovf_w[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else begin
				vld_s <= vld_w[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s  <= take ? rem_w[k] - sub : rem_w[k];
			q_s    <= q_w[k] | (take ? (DW'(1) << BIT) : '0);
			den_s  <= den_w[k];
			neg_s  <= neg_w[k];
			ovf_s  <= ovf_n;
			side_s <= side_w[k];
		end

		assign rem_w[k+1]  = rem_s;
		assign q_w[k+1]    = q_s;
		assign den_w[k+1]  = den_s;
		assign neg_w[k+1]  = neg_s;
		assign ovf_w[k+1]  = ovf_s;
		assign vld_w[k+1]  = vld_s;
		assign side_w[k+1] = side_s;
	end

	logic                 big;
	logic signed [DW-1:0] quot_n;
	logic                 vld_so;
	logic signed [DW-1:0] quot_so;
	logic [SIDE_W-1:0]    side_so;

	assign big = ovf_w[DW] | q_w[DW][DW-1];

	always_comb begin
		if (neg_w[DW]) begin
			quot_n = big ? SAT_MIN : DW'(~q_w[DW] + 1'b1);
		end else begin
			quot_n = big ? SAT_MAX : q_w[DW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else begin
			vld_so <= vld_w[DW];
		end
	end

	always_ff @(posedge clk) begin
		quot_so <= quot_n;
		side_so <= side_w[DW];
	end

	assign out_valid = vld_so;
	assign quot      = quot_so;
	assign out_side  = side_so;

endmodule

### rtl/core/cholesky_3x3_stress_check.sv
// Top level of the 3x3 stress tensor Cholesky check pipeline.
`timescale 1ns / 1ps
// Takes one symmetric tensor on every clock where start is high and returns its
// lower Cholesky factor and a status at the end of the pipeline, as a one-cycle
// done pulse; the results are not held, so the receiver must take them in that
// cycle. busy is always low: a new tensor may enter every cycle. The latency is
// set by three root units that resolve one root bit per stage and by three dividers,
// two of them side by side, that resolve one quotient bit per stage. Factor fields
// are zero whenever status is not ok.
module cholesky_3x3_stress_check import chol3_pkg::*; #(
	parameter int FRAC_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [DW-1:0] r_xx,
	input  logic signed [DW-1:0] r_xy,
	input  logic signed [DW-1:0] r_xz,
	input  logic signed [DW-1:0] r_yy,
	input  logic signed [DW-1:0] r_yz,
	input  logic signed [DW-1:0] r_zz,
	output logic                 done,
	output logic [2:0]           status,
	output logic [RT_W-1:0]      l_xx,
	output logic signed [DW-1:0] l_xy,
	output logic signed [DW-1:0] l_xz,
	output logic [RT_W-1:0]      l_yy,
	output logic signed [DW-1:0] l_yz,
	output logic [RT_W-1:0]      l_zz
);

	localparam int SQ_IN  = RT_W + FRAC_BITS;
	localparam int SQ_OUT = (SQ_IN + 1) / 2;
	localparam int NUM1_W = DW + FRAC_BITS;

	assign busy = 1'b0;

	// s1: input beat
	logic                 v_s1;
	status_t              st_s1;
	logic signed [DW-1:0] r_xx_s1, r_xy_s1, r_xz_s1, r_yy_s1, r_yz_s1, r_zz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		st_s1   <= (r_xx[DW-1] || r_xx == '0) ? ST_XX_NONPOS : ST_OK;
		r_xx_s1 <= r_xx;
		r_xy_s1 <= r_xy;
		r_xz_s1 <= r_xz;
		r_yy_s1 <= r_yy;
		r_yz_s1 <= r_yz;
		r_zz_s1 <= r_zz;
	end

	// l_xx root
	sq1_side_t         sq1_in, sq1_out;
	logic              sq1_v;
	logic [SQ_OUT-1:0] sq1_root;

	assign sq1_in = '{st: st_s1, r_xy: r_xy_s1, r_xz: r_xz_s1, r_yy: r_yy_s1,
		r_yz: r_yz_s1, r_zz: r_zz_s1};

	chol3_sqrt #(.IN_W(SQ_IN), .SIDE_W($bits(sq1_side_t))) u_sqrt_xx (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.radicand ({r_xx_s1[RT_W-1:0], {FRAC_BITS{1'b0}}}),
		.in_side  (sq1_in),
		.out_valid(sq1_v),
		.root     (sq1_root),
		.out_side (sq1_out)
	);

	// l_xy and l_xz divides
	dv1_side_t            dv1_in, dv1_out;
	logic                 dv1_v;
	logic signed [DW-1:0] dv1_xy, dv1_xz;
	logic [DW-1:0]        dv1_zz;
	logic [RT_W-1:0]      l_xx_d;

	assign l_xx_d = RT_W'(sq1_root);
	assign dv1_in = '{st: sq1_out.st, l_xx: l_xx_d, r_yy: sq1_out.r_yy,
		r_yz: sq1_out.r_yz};

	chol3_div #(.NUM_W(NUM1_W), .DEN_W(RT_W), .SIDE_W($bits(dv1_side_t))) u_div_xy (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq1_v),
		.num      ({sq1_out.r_xy, {FRAC_BITS{1'b0}}}),
		.den      (l_xx_d),
		.in_side  (dv1_in),
		.out_valid(dv1_v),
		.quot     (dv1_xy),
		.out_side (dv1_out)
	);

	chol3_div #(.NUM_W(NUM1_W), .DEN_W(RT_W), .SIDE_W(DW)) u_div_xz (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq1_v),
		.num      ({sq1_out.r_xz, {FRAC_BITS{1'b0}}}),
		.den      (l_xx_d),
		.in_side  (sq1_out.r_zz),
		.out_valid(),
		.quot     (dv1_xz),
		.out_side (dv1_zz)
	);

	// s2: squares and cross product
	logic                   v_s2;
	status_t                st_s2;
	logic [RT_W-1:0]        l_xx_s2;
	logic signed [DW-1:0]   l_xy_s2, l_xz_s2, r_yy_s2, r_yz_s2, r_zz_s2;
	logic signed [2*DW-1:0] sq_xy_s2, sq_xz_s2, pxz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= dv1_v;
		end
	end

	always_ff @(posedge clk) begin
		st_s2    <= dv1_out.st;
		l_xx_s2  <= dv1_out.l_xx;
		l_xy_s2  <= dv1_xy;
		l_xz_s2  <= dv1_xz;
		r_yy_s2  <= dv1_out.r_yy;
		r_yz_s2  <= dv1_out.r_yz;
		r_zz_s2  <= dv1_zz;
		sq_xy_s2 <= dv1_xy * dv1_xy;
		sq_xz_s2 <= dv1_xz * dv1_xz;
		pxz_s2   <= dv1_xy * dv1_xz;
	end

	// s3: second pivot, l_yz numerator, partial third pivot
	logic signed [2*DW-1:0] p2_n;
	logic                   v_s3;
	status_t                st_s3;
	logic [RT_W-1:0]        l_xx_s3;
	logic signed [DW-1:0]   l_xy_s3, l_xz_s3;
	logic signed [2*DW-1:0] p2_s3, nyz_s3, q3a_s3;

	assign p2_n = $signed({{DW{r_yy_s2[DW-1]}}, r_yy_s2}) - (sq_xy_s2 >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (st_s2 != ST_OK) begin
			st_s3 <= st_s2;
		end else if (p2_n[2*DW-1]) begin
			st_s3 <= ST_P2_NEG;
		end else if (p2_n == '0) begin
			st_s3 <= ST_P2_ZERO;
		end else begin
			st_s3 <= ST_OK;
		end
		l_xx_s3 <= l_xx_s2;
		l_xy_s3 <= l_xy_s2;
		l_xz_s3 <= l_xz_s2;
		p2_s3   <= p2_n;
		nyz_s3  <= ($signed({{DW{r_yz_s2[DW-1]}}, r_yz_s2}) <<< FRAC_BITS) - pxz_s2;
		q3a_s3  <= $signed({{DW{r_zz_s2[DW-1]}}, r_zz_s2}) - (sq_xz_s2 >>> FRAC_BITS);
	end

	// l_yy root
	sq2_side_t         sq2_in, sq2_out;
	logic              sq2_v;
	logic [SQ_OUT-1:0] sq2_root;

	assign sq2_in = '{st: st_s3, l_xx: l_xx_s3, l_xy: l_xy_s3, l_xz: l_xz_s3,
		nyz: nyz_s3, q3a: q3a_s3};

	chol3_sqrt #(.IN_W(SQ_IN), .SIDE_W($bits(sq2_side_t))) u_sqrt_yy (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.radicand ({p2_s3[RT_W-1:0], {FRAC_BITS{1'b0}}}),
		.in_side  (sq2_in),
		.out_valid(sq2_v),
		.root     (sq2_root),
		.out_side (sq2_out)
	);

	// l_yz divide
	dv2_side_t            dv2_in, dv2_out;
	logic                 dv2_v;
	logic signed [DW-1:0] dv2_yz;
	logic [RT_W-1:0]      l_yy_d;

	assign l_yy_d = RT_W'(sq2_root);
	assign dv2_in = '{st: sq2_out.st, l_xx: sq2_out.l_xx, l_xy: sq2_out.l_xy,
		l_xz: sq2_out.l_xz, l_yy: l_yy_d, q3a: sq2_out.q3a};

	chol3_div #(.NUM_W(2*DW), .DEN_W(RT_W), .SIDE_W($bits(dv2_side_t))) u_div_yz (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq2_v),
		.num      (sq2_out.nyz),
		.den      (l_yy_d),
		.in_side  (dv2_in),
		.out_valid(dv2_v),
		.quot     (dv2_yz),
		.out_side (dv2_out)
	);

	// s4: l_yz square
	logic                   v_s4;
	dv2_side_t              sd_s4;
	logic signed [DW-1:0]   l_yz_s4;
	logic signed [2*DW-1:0] sq_yz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= dv2_v;
		end
	end

	always_ff @(posedge clk) begin
		sd_s4    <= dv2_out;
		l_yz_s4  <= dv2_yz;
		sq_yz_s4 <= dv2_yz * dv2_yz;
	end

	// s5: third pivot
	logic signed [2*DW-1:0] p3_n;
	logic                   v_s5;
	sq3_side_t              sd_s5;
	logic signed [2*DW-1:0] p3_s5;

	assign p3_n = sd_s4.q3a - (sq_yz_s4 >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sd_s5.st   <= (sd_s4.st == ST_OK && p3_n[2*DW-1]) ? ST_P3_NEG : sd_s4.st;
		sd_s5.l_xx <= sd_s4.l_xx;
		sd_s5.l_xy <= sd_s4.l_xy;
		sd_s5.l_xz <= sd_s4.l_xz;
		sd_s5.l_yy <= sd_s4.l_yy;
		sd_s5.l_yz <= l_yz_s4;
		p3_s5      <= p3_n;
	end

	// l_zz root
	sq3_side_t         sq3_out;
	logic              sq3_v;
	logic [SQ_OUT-1:0] sq3_root;

	chol3_sqrt #(.IN_W(SQ_IN), .SIDE_W($bits(sq3_side_t))) u_sqrt_zz (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.radicand ({p3_s5[RT_W-1:0], {FRAC_BITS{1'b0}}}),
		.in_side  (sd_s5),
		.out_valid(sq3_v),
		.root     (sq3_root),
		.out_side (sq3_out)
	);

	// s6: result beat, factor cleared on any failed check
	logic                 done_s6;
	status_t              st_s6;
	logic [RT_W-1:0]      l_xx_s6, l_yy_s6, l_zz_s6;
	logic signed [DW-1:0] l_xy_s6, l_xz_s6, l_yz_s6;
	logic                 ok;

	assign ok = sq3_out.st == ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= sq3_v;
		end
	end

	always_ff @(posedge clk) begin
		st_s6   <= sq3_out.st;
		l_xx_s6 <= ok ? sq3_out.l_xx : '0;
		l_xy_s6 <= ok ? sq3_out.l_xy : '0;
		l_xz_s6 <= ok ? sq3_out.l_xz : '0;
		l_yy_s6 <= ok ? sq3_out.l_yy : '0;
		l_yz_s6 <= ok ? sq3_out.l_yz : '0;
		l_zz_s6 <= ok ? RT_W'(sq3_root) : '0;
	end

	assign done   = done_s6;
	assign status = st_s6;
	assign l_xx   = l_xx_s6;
	assign l_xy   = l_xy_s6;
	assign l_xz   = l_xz_s6;
	assign l_yy   = l_yy_s6;
	assign l_yz   = l_yz_s6;
	assign l_zz   = l_zz_s6;

endmodule

### rtl/core/chol3_checker.sv
// Port-level checks for the Cholesky stress check, bound to the top level.
`timescale 1ns / 1ps
module chol3_checker import chol3_pkg::*; #(
	parameter int FRAC_BITS = 24
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic signed [DW-1:0] r_xx,
	input logic signed [DW-1:0] r_xy,
	input logic signed [DW-1:0] r_xz,
	input logic signed [DW-1:0] r_yy,
	input logic signed [DW-1:0] r_yz,
	input logic signed [DW-1:0] r_zz,
	input logic                 done,
	input logic [2:0]           status,
	input logic [RT_W-1:0]      l_xx,
	input logic signed [DW-1:0] l_xy,
	input logic signed [DW-1:0] l_xz,
	input logic [RT_W-1:0]      l_yy,
	input logic signed [DW-1:0] l_yz,
	input logic [RT_W-1:0]      l_zz
);

	localparam int SQ_STG = (RT_W + FRAC_BITS + 1) / 2;
	localparam int LAT    = 3 * SQ_STG + 2 * (DW + 2) + 6;

	// every accepted beat comes out after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result beat missing");

	// no result beat without a matching input beat
	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without input beat");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> l_xx == '0 && l_xy == '0 && l_xz == '0 &&
			l_yy == '0 && l_yz == '0 && l_zz == '0)
		else $error("factor not cleared on failed check");

	// positive first and second pivots give nonzero roots
	a_ok_roots: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_OK |-> l_xx != '0 && l_yy != '0)
		else $error("zero root on accepted tensor");

endmodule

bind cholesky_3x3_stress_check chol3_checker #(.FRAC_BITS(FRAC_BITS)) u_chol3_checker (.*);
